>>> sv/look_at_view_matrix_macros.svh
// ----------------------------------------------------------------------------
// look_at_view_matrix assertion macros
// Shared property wrappers for the view matrix block, clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// same-cycle implication
`define LAT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LAT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lat_pkg.sv
// ----------------------------------------------------------------------------
// lat_pkg
// Types, widths and helpers shared by the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lat_pkg;

   localparam int COORD_W     = 32;
   localparam int MAG_W       = 33;
   localparam int RAD_W       = 66;
   localparam int ROOT_W      = 34;
   localparam int REM_W       = ROOT_W + 3;
   localparam int QUO_W       = 17;
   localparam int UNIT_W      = 18;
   localparam int SQRT_STAGES = RAD_W / 2;
   localparam int DIV_STAGES  = QUO_W;
   localparam int NUM_COLS    = 4;

   localparam logic [1:0]                  LAST_COL = 2'(NUM_COLS - 1);
   localparam logic [1:0]                  GAP_CYCLES = 2'(NUM_COLS - 1);
   localparam logic [ROOT_W-1:0]           EPS_LEN  = 34'd7;
   localparam logic signed [UNIT_W-1:0]    UNIT_ONE = 18'sd65536;
   localparam logic signed [COORD_W-1:0]   ELEM_ONE = 32'sd65536;

   typedef logic [ROOT_W-1:0]        root_type;
   typedef logic [MAG_W-1:0]         mag_type;
   typedef logic [QUO_W-1:0]         quo_type;
   typedef logic signed [UNIT_W-1:0] unit_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] eye_x;
      logic signed [COORD_W-1:0] eye_y;
      logic signed [COORD_W-1:0] eye_z;
      logic signed [COORD_W-1:0] aim_x;
      logic signed [COORD_W-1:0] aim_y;
      logic signed [COORD_W-1:0] aim_z;
   } req_type;

   typedef struct packed {
      logic [1:0]                column_index;
      logic signed [COORD_W-1:0] elem_row0;
      logic signed [COORD_W-1:0] elem_row1;
      logic signed [COORD_W-1:0] elem_row2;
      logic signed [COORD_W-1:0] elem_row3;
      logic                      final_column;
   } rsp_type;

   // sideband next to the forward square root
   typedef struct packed {
      logic [2:0][COORD_W-1:0] eye;
      logic [2:0][MAG_W-1:0]   mag;
      logic [2:0]              neg;
   } side_a_type;

   // sideband next to the forward dividers
   typedef struct packed {
      logic [2:0][COORD_W-1:0] eye;
      logic [2:0]              neg;
      logic                    eps;
   } side_b_type;

   // sideband next to the right square root
   typedef struct packed {
      logic [2:0][COORD_W-1:0] eye;
      logic [2:0][UNIT_W-1:0]  fwd;
   } side_c_type;

   // sideband next to the right dividers
   typedef struct packed {
      logic [2:0][COORD_W-1:0] eye;
      logic [2:0][UNIT_W-1:0]  fwd;
      logic                    eps;
   } side_d_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [39:0] v);
      logic signed [39:0] hi_lim;
      logic signed [39:0] lo_lim;
      hi_lim = 40'sd2147483647;
      lo_lim = -40'sd2147483648;
      if (v > hi_lim) begin
         return 32'sh7fffffff;
      end else if (v < lo_lim) begin
         return 32'sh80000000;
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

>>> sv/lat_isqrt.sv
// ----------------------------------------------------------------------------
// lat_isqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module lat_isqrt (
   input  logic                      clock,
   input  logic [lat_pkg::RAD_W-1:0] radicand,
   output lat_pkg::root_type         root
);
   import lat_pkg::*;

   logic [RAD_W-1:0] rad_ff  [SQRT_STAGES];
   logic [REM_W-1:0] rem_ff  [SQRT_STAGES];
   root_type         root_ff [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
      localparam int Pos = RAD_W - 2 - 2 * k;
      logic [RAD_W-1:0] rad_prev;
      logic [REM_W-1:0] rem_prev;
      root_type         root_prev;
      logic [REM_W-1:0] rem_in;
      logic [REM_W-1:0] trial;

      if (k == 0) begin : g_first
         assign rad_prev  = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // bring down the next bit pair and try the trial subtrahend
      assign rem_in = {rem_prev[REM_W-3:0], rad_prev[Pos+1:Pos]};
      assign trial  = {1'b0, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         rad_ff[k] <= rad_prev;
         if (rem_in >= trial) begin
            rem_ff[k]  <= rem_in - trial;
            root_ff[k] <= {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {root_prev[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

>>> sv/lat_div.sv
// ----------------------------------------------------------------------------
// lat_div
// Pipelined restoring divider: (dividend * 65536) / divisor, 17 quotient bits,
// one bit per stage. Valid when the dividend does not exceed the divisor.
// ----------------------------------------------------------------------------
module lat_div (
   input  logic              clock,
   input  lat_pkg::mag_type  dividend,
   input  lat_pkg::root_type divisor,
   output lat_pkg::quo_type  quotient
);
   import lat_pkg::*;

   root_type rem_ff [DIV_STAGES];
   root_type den_ff [DIV_STAGES];
   quo_type  quo_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
      logic [ROOT_W:0] rem_in;
      root_type        den_prev;
      quo_type         quo_prev;

      // the first stage brings down the whole magnitude, the rest shift in zeros
      if (k == 0) begin : g_first
         assign rem_in   = (ROOT_W + 1)'(dividend);
         assign den_prev = divisor;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_in   = {rem_ff[k-1], 1'b0};
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      always_ff @(posedge clock) begin
         den_ff[k] <= den_prev;
         if (rem_in >= {1'b0, den_prev}) begin
            rem_ff[k] <= ROOT_W'(rem_in - {1'b0, den_prev});
            quo_ff[k] <= {quo_prev[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff[k] <= ROOT_W'(rem_in);
            quo_ff[k] <= {quo_prev[QUO_W-2:0], 1'b0};
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

>>> sv/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Builds a Q16.16 look-at view matrix from an eye and a target position and
// streams it out as four columns.
// ----------------------------------------------------------------------------
// A request (eye, target) is taken when start is high and busy is low. The
// matrix leaves as four consecutive column results, columns 0 to 3, one per
// cycle, each marked by rsp_valid for a single cycle. After each request busy
// stays high while a spacing counter loaded with GAP_CYCLES counts down, so
// requests are spaced to match the four-column burst on the result port.
// Inside, a 112-stage pipeline (two bit-per-stage square roots and dividers
// plus multiply stages) holds up to 28 requests in flight. The receiver cannot
// hold results off.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_macros.svh"

module look_at_view_matrix (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lat_pkg::req_type req_data,
   output logic             rsp_valid,
   output lat_pkg::rsp_type rsp_data
);
   import lat_pkg::*;

   // request spacing
   logic       accept;
   logic [1:0] gap_ff;
   logic [1:0] gap_in;

   // forward difference, magnitudes and squares
   logic                      s1_vld_ff;
   logic [2:0][COORD_W-1:0]   s1_eye_ff;
   logic signed [MAG_W-1:0]   s1_d_ff [3];
   logic                      s2_vld_ff;
   side_a_type                s2_side_ff;
   logic                      s3_vld_ff;
   side_a_type                s3_side_ff;
   logic [RAD_W-1:0]          s3_sq_ff [3];
   logic                      s4_vld_ff;
   side_a_type                s4_side_ff;
   logic [RAD_W-1:0]          s4_rad_ff;

   // forward length and normalization
   root_type                  len_fwd;
   logic                      eps_fwd;
   logic [SQRT_STAGES-1:0]    va_ff;
   side_a_type                sa_ff [SQRT_STAGES];
   side_a_type                sa_end;
   quo_type                   q_fwd [3];
   side_b_type                sb_src;
   logic [DIV_STAGES-1:0]     vb_ff;
   side_b_type                sb_ff [DIV_STAGES];
   side_b_type                sb_end;

   logic                      f_vld_ff;
   unit_type                  f_ff [3];
   logic [2:0][COORD_W-1:0]   f_eye_ff;

   // right vector length and normalization
   logic signed [35:0]        fzz;
   logic signed [35:0]        fxx;
   logic                      r1_vld_ff;
   side_c_type                r1_side_ff;
   mag_type                   r1_sqz_ff;
   mag_type                   r1_sqx_ff;
   logic                      r2_vld_ff;
   side_c_type                r2_side_ff;
   logic [RAD_W-1:0]          r2_rad_ff;

   root_type                  len_right;
   logic [SQRT_STAGES-1:0]    vc_ff;
   side_c_type                sc_ff [SQRT_STAGES];
   side_c_type                sc_end;
   unit_type                  sc_fz;
   unit_type                  sc_fx;
   logic [UNIT_W-1:0]         abs_fz;
   logic [UNIT_W-1:0]         abs_fx;
   quo_type                   q_right [2];
   side_d_type                sd_src;
   logic [DIV_STAGES-1:0]     vd_ff;
   side_d_type                sd_ff [DIV_STAGES];
   side_d_type                sd_end;

   logic                      g_vld_ff;
   unit_type                  g_rx_ff;
   unit_type                  g_rz_ff;
   unit_type                  g_f_ff [3];
   logic [2:0][COORD_W-1:0]   g_eye_ff;

   // up vector and translation products
   logic                      u1_vld_ff;
   unit_type                  u1_rx_ff;
   unit_type                  u1_rz_ff;
   unit_type                  u1_f_ff [3];
   logic [2:0][COORD_W-1:0]   u1_eye_ff;
   logic signed [35:0]        u1_rzfy_ff;
   logic signed [35:0]        u1_rzfx_ff;
   logic signed [35:0]        u1_rxfz_ff;
   logic signed [35:0]        u1_rxfy_ff;
   logic signed [49:0]        u1_t0_ff [2];
   logic signed [49:0]        u1_t2_ff [3];

   logic signed [36:0]        ux_full;
   logic signed [36:0]        uy_full;
   logic signed [36:0]        uz_full;
   logic                      u2_vld_ff;
   unit_type                  u2_rx_ff;
   unit_type                  u2_rz_ff;
   unit_type                  u2_f_ff [3];
   logic [2:0][COORD_W-1:0]   u2_eye_ff;
   logic signed [20:0]        u2_u_ff [3];
   logic signed [55:0]        u2_s0_ff;
   logic signed [55:0]        u2_s2_ff;

   logic                      t1_vld_ff;
   unit_type                  t1_rx_ff;
   unit_type                  t1_rz_ff;
   unit_type                  t1_f_ff [3];
   logic signed [20:0]        t1_u_ff [3];
   logic signed [55:0]        t1_s0_ff;
   logic signed [55:0]        t1_s2_ff;
   logic signed [52:0]        t1_p_ff [3];
   logic signed [55:0]        s1_sum;

   // column burst
   logic signed [COORD_W-1:0] cols_ff [NUM_COLS][3];
   logic                      seq_act_ff;
   logic [1:0]                seq_cnt_ff;

   // request handshake and spacing counter
   assign accept = start && !busy;
   assign busy   = (gap_ff != 2'd0);
   assign gap_in = accept ? GAP_CYCLES : (busy ? gap_ff - 2'd1 : 2'd0);

   // valid bits and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         va_ff      <= '0;
         vb_ff      <= '0;
         f_vld_ff   <= 1'b0;
         r1_vld_ff  <= 1'b0;
         r2_vld_ff  <= 1'b0;
         vc_ff      <= '0;
         vd_ff      <= '0;
         g_vld_ff   <= 1'b0;
         u1_vld_ff  <= 1'b0;
         u2_vld_ff  <= 1'b0;
         t1_vld_ff  <= 1'b0;
         seq_act_ff <= 1'b0;
         seq_cnt_ff <= '0;
      end else begin
         gap_ff    <= gap_in;
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         va_ff     <= {va_ff[SQRT_STAGES-2:0], s4_vld_ff};
         vb_ff     <= {vb_ff[DIV_STAGES-2:0], va_ff[SQRT_STAGES-1]};
         f_vld_ff  <= vb_ff[DIV_STAGES-1];
         r1_vld_ff <= f_vld_ff;
         r2_vld_ff <= r1_vld_ff;
         vc_ff     <= {vc_ff[SQRT_STAGES-2:0], r2_vld_ff};
         vd_ff     <= {vd_ff[DIV_STAGES-2:0], vc_ff[SQRT_STAGES-1]};
         g_vld_ff  <= vd_ff[DIV_STAGES-1];
         u1_vld_ff <= g_vld_ff;
         u2_vld_ff <= u1_vld_ff;
         t1_vld_ff <= u2_vld_ff;
         if (t1_vld_ff) begin
            seq_act_ff <= 1'b1;
            seq_cnt_ff <= '0;
         end else if (seq_act_ff) begin
            if (seq_cnt_ff == LAST_COL) begin
               seq_act_ff <= 1'b0;
            end else begin
               seq_cnt_ff <= seq_cnt_ff + 2'd1;
            end
         end
      end
   end

   // forward difference, magnitude, square and sum of squares
   always_ff @(posedge clock) begin
      s1_eye_ff  <= {req_data.eye_z, req_data.eye_y, req_data.eye_x};
      s1_d_ff[0] <= MAG_W'(req_data.aim_x) - MAG_W'(req_data.eye_x);
      s1_d_ff[1] <= MAG_W'(req_data.aim_y) - MAG_W'(req_data.eye_y);
      s1_d_ff[2] <= MAG_W'(req_data.aim_z) - MAG_W'(req_data.eye_z);

      s2_side_ff.eye <= s1_eye_ff;
      for (int j = 0; j < 3; j++) begin
         s2_side_ff.neg[j] <= s1_d_ff[j][MAG_W-1];
         s2_side_ff.mag[j] <= s1_d_ff[j][MAG_W-1] ? mag_type'(-s1_d_ff[j])
                                                  : mag_type'(s1_d_ff[j]);
      end

      s3_side_ff <= s2_side_ff;
      for (int j = 0; j < 3; j++) begin
         s3_sq_ff[j] <= RAD_W'(s2_side_ff.mag[j]) * RAD_W'(s2_side_ff.mag[j]);
      end

      s4_side_ff <= s3_side_ff;
      s4_rad_ff  <= s3_sq_ff[0] + s3_sq_ff[1] + s3_sq_ff[2];
   end

   // forward length
   lat_isqrt u_sqrt_fwd (
      .clock    (clock),
      .radicand (s4_rad_ff),
      .root     (len_fwd)
   );

   always_ff @(posedge clock) begin
      sa_ff[0] <= s4_side_ff;
      for (int k = 1; k < SQRT_STAGES; k++) begin
         sa_ff[k] <= sa_ff[k-1];
      end
   end

   assign sa_end  = sa_ff[SQRT_STAGES-1];
   assign eps_fwd = (len_fwd < EPS_LEN);

   // forward unit components
   for (genvar j = 0; j < 3; j++) begin : g_div_fwd
      lat_div u_div (
         .clock    (clock),
         .dividend (sa_end.mag[j]),
         .divisor  (len_fwd),
         .quotient (q_fwd[j])
      );
   end

   assign sb_src.eye = sa_end.eye;
   assign sb_src.neg = sa_end.neg;
   assign sb_src.eps = eps_fwd;

   always_ff @(posedge clock) begin
      sb_ff[0] <= sb_src;
      for (int k = 1; k < DIV_STAGES; k++) begin
         sb_ff[k] <= sb_ff[k-1];
      end
   end

   assign sb_end = sb_ff[DIV_STAGES-1];

   // sign and short-forward fallback to (0,0,-1)
   always_ff @(posedge clock) begin
      f_eye_ff <= sb_end.eye;
      for (int j = 0; j < 3; j++) begin
         if (sb_end.eps) begin
            f_ff[j] <= (j == 2) ? -UNIT_ONE : '0;
         end else if (sb_end.neg[j]) begin
            f_ff[j] <= -$signed({1'b0, q_fwd[j]});
         end else begin
            f_ff[j] <= $signed({1'b0, q_fwd[j]});
         end
      end
   end

   // right = (-fz, 0, fx): squared length
   assign fzz = f_ff[2] * f_ff[2];
   assign fxx = f_ff[0] * f_ff[0];

   always_ff @(posedge clock) begin
      r1_side_ff.eye <= f_eye_ff;
      for (int j = 0; j < 3; j++) begin
         r1_side_ff.fwd[j] <= f_ff[j];
      end
      r1_sqz_ff <= fzz[MAG_W-1:0];
      r1_sqx_ff <= fxx[MAG_W-1:0];

      r2_side_ff <= r1_side_ff;
      r2_rad_ff  <= RAD_W'(r1_sqz_ff) + RAD_W'(r1_sqx_ff);
   end

   lat_isqrt u_sqrt_right (
      .clock    (clock),
      .radicand (r2_rad_ff),
      .root     (len_right)
   );

   always_ff @(posedge clock) begin
      sc_ff[0] <= r2_side_ff;
      for (int k = 1; k < SQRT_STAGES; k++) begin
         sc_ff[k] <= sc_ff[k-1];
      end
   end

   assign sc_end = sc_ff[SQRT_STAGES-1];
   assign sc_fz  = $signed(sc_end.fwd[2]);
   assign sc_fx  = $signed(sc_end.fwd[0]);
   assign abs_fz = sc_fz[UNIT_W-1] ? UNIT_W'(-sc_fz) : UNIT_W'(sc_fz);
   assign abs_fx = sc_fx[UNIT_W-1] ? UNIT_W'(-sc_fx) : UNIT_W'(sc_fx);

   // right unit components
   lat_div u_div_rx (
      .clock    (clock),
      .dividend (MAG_W'(abs_fz)),
      .divisor  (len_right),
      .quotient (q_right[0])
   );

   lat_div u_div_rz (
      .clock    (clock),
      .dividend (MAG_W'(abs_fx)),
      .divisor  (len_right),
      .quotient (q_right[1])
   );

   assign sd_src.eye = sc_end.eye;
   assign sd_src.fwd = sc_end.fwd;
   assign sd_src.eps = (len_right < EPS_LEN);

   always_ff @(posedge clock) begin
      sd_ff[0] <= sd_src;
      for (int k = 1; k < DIV_STAGES; k++) begin
         sd_ff[k] <= sd_ff[k-1];
      end
   end

   assign sd_end = sd_ff[DIV_STAGES-1];

   // sign and forward-parallel-to-up fallback to (1,0,0)
   always_ff @(posedge clock) begin
      g_eye_ff <= sd_end.eye;
      for (int j = 0; j < 3; j++) begin
         g_f_ff[j] <= $signed(sd_end.fwd[j]);
      end
      if (sd_end.eps) begin
         g_rx_ff <= UNIT_ONE;
         g_rz_ff <= '0;
      end else begin
         g_rx_ff <= ($signed(sd_end.fwd[2]) > 0) ? -$signed({1'b0, q_right[0]})
                                                 : $signed({1'b0, q_right[0]});
         g_rz_ff <= ($signed(sd_end.fwd[0]) < 0) ? -$signed({1'b0, q_right[1]})
                                                 : $signed({1'b0, q_right[1]});
      end
   end

   // cross-product terms and the right/forward translation products
   always_ff @(posedge clock) begin
      u1_rx_ff   <= g_rx_ff;
      u1_rz_ff   <= g_rz_ff;
      u1_f_ff    <= g_f_ff;
      u1_eye_ff  <= g_eye_ff;
      u1_rzfy_ff <= g_rz_ff * g_f_ff[1];
      u1_rzfx_ff <= g_rz_ff * g_f_ff[0];
      u1_rxfz_ff <= g_rx_ff * g_f_ff[2];
      u1_rxfy_ff <= g_rx_ff * g_f_ff[1];
      u1_t0_ff[0] <= g_rx_ff * $signed(g_eye_ff[0]);
      u1_t0_ff[1] <= g_rz_ff * $signed(g_eye_ff[2]);
      for (int j = 0; j < 3; j++) begin
         u1_t2_ff[j] <= g_f_ff[j] * $signed(g_eye_ff[j]);
      end
   end

   // up = right x forward, floored to Q16.16
   assign ux_full = -37'(u1_rzfy_ff);
   assign uy_full = 37'(u1_rzfx_ff) - 37'(u1_rxfz_ff);
   assign uz_full = 37'(u1_rxfy_ff);

   always_ff @(posedge clock) begin
      u2_rx_ff   <= u1_rx_ff;
      u2_rz_ff   <= u1_rz_ff;
      u2_f_ff    <= u1_f_ff;
      u2_eye_ff  <= u1_eye_ff;
      u2_u_ff[0] <= ux_full[36:16];
      u2_u_ff[1] <= uy_full[36:16];
      u2_u_ff[2] <= uz_full[36:16];
      u2_s0_ff   <= -(56'(u1_t0_ff[0]) + 56'(u1_t0_ff[1]));
      u2_s2_ff   <= 56'(u1_t2_ff[0]) + 56'(u1_t2_ff[1]) + 56'(u1_t2_ff[2]);
   end

   // up translation products
   always_ff @(posedge clock) begin
      t1_rx_ff <= u2_rx_ff;
      t1_rz_ff <= u2_rz_ff;
      t1_f_ff  <= u2_f_ff;
      t1_u_ff  <= u2_u_ff;
      t1_s0_ff <= u2_s0_ff;
      t1_s2_ff <= u2_s2_ff;
      for (int j = 0; j < 3; j++) begin
         t1_p_ff[j] <= u2_u_ff[j] * $signed(u2_eye_ff[j]);
      end
   end

   assign s1_sum = -(56'(t1_p_ff[0]) + 56'(t1_p_ff[1]) + 56'(t1_p_ff[2]));

   // load the finished matrix into the column holding registers
   always_ff @(posedge clock) begin
      if (t1_vld_ff) begin
         cols_ff[0][0] <= 32'(t1_rx_ff);
         cols_ff[0][1] <= '0;
         cols_ff[0][2] <= 32'(t1_rz_ff);
         for (int j = 0; j < 3; j++) begin
            cols_ff[1][j] <= 32'(t1_u_ff[j]);
            cols_ff[2][j] <= -32'(t1_f_ff[j]);
         end
         cols_ff[3][0] <= sat32(t1_s0_ff[55:16]);
         cols_ff[3][1] <= sat32(s1_sum[55:16]);
         cols_ff[3][2] <= sat32(t1_s2_ff[55:16]);
      end
   end

   // result port
   assign rsp_valid             = seq_act_ff;
   assign rsp_data.column_index = seq_cnt_ff;
   assign rsp_data.elem_row0    = cols_ff[seq_cnt_ff][0];
   assign rsp_data.elem_row1    = cols_ff[seq_cnt_ff][1];
   assign rsp_data.elem_row2    = cols_ff[seq_cnt_ff][2];
   assign rsp_data.elem_row3    = (seq_cnt_ff == LAST_COL) ? ELEM_ONE : '0;
   assign rsp_data.final_column = (seq_cnt_ff == LAST_COL);

   // a taken request holds off the next one
   `LAT_ASSERT_NEXT(a_busy_after_accept, accept, busy, "request taken without spacing")
   // a finished matrix never lands in the middle of a column burst
   `LAT_ASSERT_NOW(a_no_cut_in, t1_vld_ff, !seq_act_ff || (seq_cnt_ff == LAST_COL), "matrix overran burst")
   // columns of one matrix follow in consecutive cycles
   `LAT_ASSERT_NEXT(a_burst_order, rsp_valid && !rsp_data.final_column, rsp_valid && (rsp_data.column_index == $past(rsp_data.column_index) + 2'd1), "column burst broken")

endmodule
